// File: design/cfpc_pkg.sv
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the frame checker.
// No dependencies; imported by cfpc_frame_parse and crc_framed_packet_checker_core.
package cfpc_pkg;

  // Frame layout.
  localparam int unsigned HdrLen   = 8;
  localparam int unsigned CrcLen   = 2;
  localparam int unsigned IdxW     = 17;
  localparam int unsigned CountW   = IdxW + 1;
  localparam logic [IdxW-1:0] IdxMax = {IdxW{1'b1}};

  localparam logic [IdxW-1:0] POS_START   = 17'd0;
  localparam logic [IdxW-1:0] POS_VERSION = 17'd1;
  localparam logic [IdxW-1:0] POS_FLAGS   = 17'd2;
  localparam logic [IdxW-1:0] POS_COMMAND = 17'd3;
  localparam logic [IdxW-1:0] POS_SEQ_LO  = 17'd4;
  localparam logic [IdxW-1:0] POS_SEQ_HI  = 17'd5;
  localparam logic [IdxW-1:0] POS_LEN_LO  = 17'd6;
  localparam logic [IdxW-1:0] POS_LEN_HI  = 17'd7;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // Configuration register indexes.
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgAddrW-1:0] CFG_START_BYTE   = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_VERSION_BYTE = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_MAX_PAYLOAD  = 2'd2;

  localparam logic [7:0]  StartByteRst  = 8'hAA;
  localparam logic [7:0]  VersionRst    = 8'h01;
  localparam logic [15:0] MaxPayloadRst = 16'd256;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_BAD_HDR = 3'd2,
    ST_BAD_LEN = 3'd3,
    ST_BAD_CRC = 3'd4
  } status_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    status_t     status;
    logic [7:0]  frame_flags;
    logic [7:0]  command;
    logic [15:0] sequence_res;
    logic [15:0] payload_length;
  } result_t;

  localparam int unsigned OutDataW = 64;

  // One byte through the MSB-first CRC: eight shift/xor steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/cfpc_frame_parse.sv
// Frame parser: byte position, header capture, running CRC and the per-byte result.
// Depends on cfpc_pkg. The result is combinational and registered by the top level.
module cfpc_frame_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       start_byte,
  input  logic [7:0]       version_byte,
  input  logic [15:0]      max_payload,
  input  logic             item_accept,
  input  logic [7:0]       data_byte,
  input  logic             frame_end,
  output logic             res_valid,
  output cfpc_pkg::result_t res
);
  import cfpc_pkg::*;

  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic            hm_r, hm_nxt;
  logic [7:0]      flags_r, flags_nxt;
  logic [7:0]      cmd_r, cmd_nxt;
  logic [15:0]     seq_r, seq_nxt;
  logic [15:0]     len_r, len_nxt;
  logic [15:0]     rcrc_r, rcrc_nxt;

  // Values after this byte has been taken in, before any end-of-frame clear.
  logic            hm_upd;
  logic [7:0]      flags_upd, cmd_upd;
  logic [15:0]     seq_upd, len_upd, rcrc_upd, crc_upd;
  logic            is_payload;
  logic [IdxW-1:0] payload_end;
  logic [CountW-1:0] count, expected;
  status_t         status;

  always_comb begin
    hm_upd      = hm_r;
    flags_upd   = flags_r;
    cmd_upd     = cmd_r;
    seq_upd     = seq_r;
    len_upd     = len_r;
    rcrc_upd    = rcrc_r;
    is_payload  = 1'b0;
    payload_end = {1'b0, len_r} + IdxW'(HdrLen);
    priority if (idx_r == POS_START) begin
      if (data_byte != start_byte) hm_upd = 1'b0;
    end else if (idx_r == POS_VERSION) begin
      if (data_byte != version_byte) hm_upd = 1'b0;
    end else if (idx_r == POS_FLAGS) begin
      flags_upd = data_byte;
    end else if (idx_r == POS_COMMAND) begin
      cmd_upd = data_byte;
    end else if (idx_r == POS_SEQ_LO) begin
      seq_upd = {seq_r[15:8], data_byte};
    end else if (idx_r == POS_SEQ_HI) begin
      seq_upd = {data_byte, seq_r[7:0]};
    end else if (idx_r == POS_LEN_LO) begin
      len_upd = {len_r[15:8], data_byte};
    end else if (idx_r == POS_LEN_HI) begin
      len_upd = {data_byte, len_r[7:0]};
    end else if (idx_r < payload_end) begin
      is_payload = 1'b1;
    end else begin
      rcrc_upd = {data_byte, rcrc_r[15:8]};
    end

    // The start byte and the trailing CRC bytes stay out of the checksum.
    if (idx_r != POS_START && (idx_r < IdxW'(HdrLen) || is_payload)) begin
      crc_upd = crc_byte(crc_r, data_byte);
    end else begin
      crc_upd = crc_r;
    end

    count    = {1'b0, idx_r} + CountW'(1);
    expected = {2'b00, len_upd} + CountW'(HdrLen + CrcLen);
    priority if (count < CountW'(HdrLen + CrcLen)) begin
      status = ST_SHORT;
    end else if (!hm_upd) begin
      status = ST_BAD_HDR;
    end else if (len_upd > max_payload) begin
      status = ST_BAD_LEN;
    end else if (count != expected) begin
      status = ST_BAD_LEN;
    end else if (rcrc_upd != crc_upd) begin
      status = ST_BAD_CRC;
    end else begin
      status = ST_OK;
    end

    res = '0;
    if (frame_end) begin
      res.result_kind    = 1'b1;
      res.status         = status;
      res.frame_flags    = flags_upd;
      res.command        = cmd_upd;
      res.sequence_res   = seq_upd;
      res.payload_length = len_upd;
      res_valid          = 1'b1;
    end else begin
      res.payload_byte = data_byte;
      res.status       = ST_OK;
      res_valid        = is_payload && (len_r <= max_payload);
    end

    if (frame_end) begin
      idx_nxt   = '0;
      crc_nxt   = CrcInit;
      hm_nxt    = 1'b1;
      flags_nxt = '0;
      cmd_nxt   = '0;
      seq_nxt   = '0;
      len_nxt   = '0;
      rcrc_nxt  = '0;
    end else begin
      idx_nxt   = (idx_r < IdxMax) ? idx_r + IdxW'(1) : idx_r;
      crc_nxt   = crc_upd;
      hm_nxt    = hm_upd;
      flags_nxt = flags_upd;
      cmd_nxt   = cmd_upd;
      seq_nxt   = seq_upd;
      len_nxt   = len_upd;
      rcrc_nxt  = rcrc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      crc_r   <= CrcInit;
      hm_r    <= 1'b1;
      flags_r <= '0;
      cmd_r   <= '0;
      seq_r   <= '0;
      len_r   <= '0;
      rcrc_r  <= '0;
    end else if (item_accept) begin
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
      hm_r    <= hm_nxt;
      flags_r <= flags_nxt;
      cmd_r   <= cmd_nxt;
      seq_r   <= seq_nxt;
      len_r   <= len_nxt;
      rcrc_r  <= rcrc_nxt;
    end
  end

endmodule

// File: design/crc_framed_packet_checker_core.sv
// Length-prefixed frame checker with CRC-16/CCITT-FALSE: top level.
// Depends on cfpc_pkg and cfpc_frame_parse.
//
// Frames enter one byte per item on the in_ channel; in_tlast marks the last
// byte. Payload bytes are forwarded on the out_ channel with out_tuser low
// while the declared length is within max_payload. The last byte of a frame
// produces one summary item with out_tuser high carrying status and header.
// Header fields and the CRC are kept in registers that clear after every frame.
// Each result is registered in the output register, or in the skid register
// while the output register holds an untaken result. Throughput: one byte
// per cycle while in_tready is high; CRC update and status compares are combinational.
// The result register is backed by a one-item skid register, so a byte is
// still accepted while a result waits; in_tready drops only when both hold
// an item, and nothing is lost or repeated while out_tready is low.
// Reset (rst_n low at a clock edge) empties both registers, clears the
// frame state and restores the configuration registers to their defaults.
// The cfg_ port writes register cfg_addr when cfg_we is high: 0 start byte,
// 1 version byte, 2 max payload; other indexes are ignored.
module crc_framed_packet_checker_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cfpc_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [cfpc_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,  // [7:0] data_byte
  input  logic                          in_tlast,  // frame_end
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] payload_byte, [10:8] status, [18:11] frame_flags, [26:19] command,
  // [42:27] sequence_res, [58:43] payload_length, [63:59] zero
  output logic [cfpc_pkg::OutDataW-1:0] out_tdata,
  output logic                          out_tuser  // result_kind
);
  import cfpc_pkg::*;

  logic [7:0]  start_r, version_r;
  logic [15:0] max_pay_r;

  logic    in_accept;
  logic    new_valid;
  result_t new_res;

  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;
  logic    out_take;

  assign in_accept = in_tvalid && in_tready;
  assign in_tready = !skid_valid_r;
  assign out_take  = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= StartByteRst;
      version_r <= VersionRst;
      max_pay_r <= MaxPayloadRst;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_START_BYTE:   start_r   <= cfg_wdata[7:0];
        CFG_VERSION_BYTE: version_r <= cfg_wdata[7:0];
        CFG_MAX_PAYLOAD:  max_pay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cfpc_frame_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_byte   (start_r),
    .version_byte (version_r),
    .max_payload  (max_pay_r),
    .item_accept  (in_accept),
    .data_byte    (in_tdata),
    .frame_end    (in_tlast),
    .res_valid    (new_valid),
    .res          (new_res)
  );

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept && new_valid;
      end
    end else if (in_accept && new_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_r <= skid_valid_r ? skid_r : new_res;
    end
    if (out_valid_r && !out_take && !skid_valid_r) begin
      skid_r <= new_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.result_kind;
  assign out_tdata  = {5'b0, out_r.payload_length, out_r.sequence_res, out_r.command,
                       out_r.frame_flags, out_r.status, out_r.payload_byte};

  // The skid register only fills behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds an item while the output register is empty");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.status == ST_OK || out_r.status == ST_SHORT ||
                     out_r.status == ST_BAD_HDR || out_r.status == ST_BAD_LEN ||
                     out_r.status == ST_BAD_CRC))
    else $error("status code out of range");

  a_fwd_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.result_kind) |-> (out_r.status == ST_OK &&
      out_r.payload_length == 16'd0 && out_r.sequence_res == 16'd0))
    else $error("forwarded payload item carries summary fields");

  a_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.result_kind) |-> out_r.payload_byte == 8'd0)
    else $error("summary item carries a payload byte");

endmodule

// File: tb/tb.sv
// Self-checking testbench for crc_framed_packet_checker_core: directed frames and
// random framed traffic under several register settings.
// Depends on cfpc_pkg and the checker RTL; needs no files or arguments.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfpc_pkg::*;

  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned ItemsPerPhase = 150;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned MaxReports    = 40;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pay;
    status_t     status;
    logic [7:0]  flags;
    logic [7:0]  cmd;
    logic [15:0] seq;
    logic [15:0] len;
  } frame_result_t;

  typedef struct {
    logic [7:0]  sb;
    logic [7:0]  ver;
    logic [7:0]  flags;
    logic [7:0]  cmd;
    logic [15:0] seq;
    logic [15:0] len;
    int          n_bytes;  // 0 sends header, payload and CRC in full
    logic [15:0] crc_flip;
    status_t     want;
  } frame_row_t;

  // Short frame, clean frame with extreme header fields, bad header, declared
  // length over the maximum, frame ending on a payload byte, corrupted CRC.
  frame_row_t frame_rows[6] = '{
    '{8'hAA, 8'h01, 8'h00, 8'h00, 16'h0000, 16'h0000, 1,  16'h0000, ST_SHORT},
    '{8'hAA, 8'h01, 8'hFF, 8'h00, 16'hFFFF, 16'h0001, 0,  16'h0000, ST_OK},
    '{8'h55, 8'hFE, 8'h00, 8'hFF, 16'h0000, 16'h0000, 0,  16'h0000, ST_BAD_HDR},
    '{8'hAA, 8'h01, 8'h5A, 8'hA5, 16'h1234, 16'hFFFF, 10, 16'h0000, ST_BAD_LEN},
    '{8'hAA, 8'h01, 8'h01, 8'h80, 16'h8001, 16'h0003, 10, 16'h0000, ST_BAD_LEN},
    '{8'hAA, 8'h01, 8'h7F, 8'hFE, 16'h00FF, 16'h0000, 0,  16'h0001, ST_BAD_CRC}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;   // [7:0] data_byte
  logic                in_tlast = 1'b0; // frame_end
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [7:0] payload_byte, [10:8] status, [18:11] frame_flags, [26:19] command,
  // [42:27] sequence_res, [58:43] payload_length, [63:59] zero
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;       // result_kind

  // Register copies and frame state of the checker model.
  logic [7:0]  start_cfg;
  logic [7:0]  ver_cfg;
  logic [15:0] max_pay_cfg;
  logic [16:0] m_idx;
  logic [15:0] m_crc;
  logic        m_hdr_ok;
  logic [7:0]  m_flags;
  logic [7:0]  m_cmd;
  logic [15:0] m_seq;
  logic [15:0] m_len;
  logic [15:0] m_rx_crc;

  frame_result_t expected_q[$];
  int            errors = 0;
  int            results_seen = 0;
  int            idle_cycles = 0;
  int            burst_left = 0;

  crc_framed_packet_checker_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // CRC-16/CCITT-FALSE, one data bit at a time from the MSB.
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  function automatic void clear_frame_state();
    m_idx    = '0;
    m_crc    = CrcInit;
    m_hdr_ok = 1'b1;
    m_flags  = '0;
    m_cmd    = '0;
    m_seq    = '0;
    m_len    = '0;
    m_rx_crc = '0;
  endfunction

  // Advances the frame state by one accepted byte and returns the result it causes.
  function automatic void model_byte(input logic [7:0] d, input logic l,
                                     output bit has, output frame_result_t r);
    logic [16:0] pos;
    logic [17:0] count;
    bit          pay;
    pos = m_idx;
    pay = 1'b0;
    has = 1'b0;
    r   = '0;
    case (pos)
      POS_START:   if (d != start_cfg) m_hdr_ok = 1'b0;
      POS_VERSION: if (d != ver_cfg) m_hdr_ok = 1'b0;
      POS_FLAGS:   m_flags = d;
      POS_COMMAND: m_cmd = d;
      POS_SEQ_LO:  m_seq[7:0] = d;
      POS_SEQ_HI:  m_seq[15:8] = d;
      POS_LEN_LO:  m_len[7:0] = d;
      POS_LEN_HI:  m_len[15:8] = d;
      default: begin
        if ({1'b0, pos} < 18'(HdrLen) + 18'(m_len)) pay = 1'b1;
        else m_rx_crc = {d, m_rx_crc[15:8]};
      end
    endcase
    if (pos != POS_START && (pos < 17'(HdrLen) || pay)) m_crc = crc_step(m_crc, d);

    if (!l) begin
      if (pos != IdxMax) m_idx = pos + 17'd1;
      if (pay && m_len <= max_pay_cfg) begin
        has   = 1'b1;
        r.pay = d;
      end
    end else begin
      count   = {1'b0, pos} + 18'd1;
      has     = 1'b1;
      r.kind  = 1'b1;
      r.flags = m_flags;
      r.cmd   = m_cmd;
      r.seq   = m_seq;
      r.len   = m_len;
      if (count < 18'(HdrLen + CrcLen)) r.status = ST_SHORT;
      else if (!m_hdr_ok) r.status = ST_BAD_HDR;
      else if (m_len > max_pay_cfg) r.status = ST_BAD_LEN;
      else if (count != 18'(HdrLen + CrcLen) + 18'(m_len)) r.status = ST_BAD_LEN;
      else if (m_rx_crc != m_crc) r.status = ST_BAD_CRC;
      else r.status = ST_OK;
      clear_frame_state();
    end
  endfunction

  // Lays out a frame byte by byte; a nonzero n_bytes cuts it short or pads it
  // with random bytes, and crc_flip corrupts the trailing CRC.
  function automatic void build_frame(input logic [7:0] sb, input logic [7:0] ver,
                                      input logic [7:0] flags, input logic [7:0] cmd,
                                      input logic [15:0] seq, input logic [15:0] len,
                                      input int n_bytes, input logic [15:0] crc_flip,
                                      input bit fixed_pay, ref logic [7:0] q[$]);
    int          total;
    int          crc_pos;
    logic [15:0] crc;
    logic [7:0]  b;
    total   = (n_bytes > 0) ? n_bytes : 10 + int'(len);
    crc_pos = 8 + int'(len);
    crc     = CrcInit;
    q.delete();
    for (int p = 0; p < total; p++) begin
      case (p)
        0: b = sb;
        1: b = ver;
        2: b = flags;
        3: b = cmd;
        4: b = seq[7:0];
        5: b = seq[15:8];
        6: b = len[7:0];
        7: b = len[15:8];
        default: begin
          if (p < crc_pos) b = fixed_pay ? 8'(8'hFF - p) : 8'($urandom);
          else if (p == crc_pos) b = crc[7:0] ^ crc_flip[7:0];
          else if (p == crc_pos + 1) b = crc[15:8] ^ crc_flip[15:8];
          else b = 8'($urandom);
        end
      endcase
      if (p >= 1 && p < crc_pos) crc = crc_step(crc, b);
      q.push_back(b);
    end
  endfunction

  // Mostly clean frames under the current registers, the rest broken or noise.
  function automatic void random_frame(ref logic [7:0] q[$]);
    int          r;
    int          lmax;
    int          n;
    logic [15:0] len;
    logic [7:0]  sb;
    logic [7:0]  ver;
    logic [15:0] flip;
    r    = $urandom_range(0, 99);
    lmax = (int'(max_pay_cfg) < 40) ? int'(max_pay_cfg) : 40;
    len  = 16'($urandom_range(0, (lmax < 8) ? lmax : 8));
    if ($urandom_range(0, 9) == 0) len = 16'($urandom_range(0, lmax));
    if ($urandom_range(0, 19) == 0) len = 16'(lmax);
    sb   = start_cfg;
    ver  = ver_cfg;
    n    = 0;
    flip = '0;
    if (r < 60) begin
      n = 0;
    end else if (r < 68) begin
      case ($urandom_range(0, 2))
        0: sb = sb ^ 8'($urandom_range(1, 255));
        1: ver = ver ^ 8'($urandom_range(1, 255));
        default: begin
          sb  = sb ^ 8'($urandom_range(1, 255));
          ver = ver ^ 8'($urandom_range(1, 255));
        end
      endcase
    end else if (r < 76) begin
      flip = 16'($urandom_range(1, 65535));
    end else if (r < 84) begin
      n = 10 + int'(len) + ($urandom_range(0, 1) ? int'($urandom_range(1, 3))
                                                 : -int'($urandom_range(1, 3)));
    end else if (r < 88) begin
      if (max_pay_cfg == 16'hFFFF) len = 16'hFFFF;
      else len = max_pay_cfg + 16'd1 + 16'($urandom_range(0, 16'hFFFE - max_pay_cfg));
      n = $urandom_range(10, 30);
    end else if (r < 94) begin
      n = $urandom_range(1, 9);
    end else begin
      sb  = 8'($urandom);
      ver = 8'($urandom);
      len = 16'($urandom);
      n   = $urandom_range(1, 30);
    end
    build_frame(sb, ver, 8'($urandom), 8'($urandom), 16'($urandom), len, n, flip, 1'b0, q);
  endfunction

  // Offers one item in bursts with random gaps; called and returns at a falling edge.
  task automatic send_item(input logic [7:0] d, input logic l, input bit use_want,
                           input status_t want);
    int            gap;
    bit            has;
    frame_result_t r;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(50, 200);
      end else begin
        gap        = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 24);
      end
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tdata  = d;
    in_tlast  = l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_byte(d, l, has, r);
    if (has) begin
      if (use_want && r.kind) r.status = want;
      expected_q.push_back(r);
    end
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_frame(ref logic [7:0] q[$], input bit use_want, input status_t want);
    foreach (q[i]) send_item(q[i], i == q.size() - 1, use_want, want);
  endtask

  // Stops sending and waits until every expected result has come out.
  task automatic settle();
    in_tvalid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] a, input logic [CfgDataW-1:0] v);
    cfg_we    = 1'b1;
    cfg_addr  = a;
    cfg_wdata = v;
    case (a)
      CFG_START_BYTE:   start_cfg = v[7:0];
      CFG_VERSION_BYTE: ver_cfg = v[7:0];
      CFG_MAX_PAYLOAD:  max_pay_cfg = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  initial begin : stimulus
    logic [7:0] fb[$];
    int         sent;
    start_cfg   = StartByteRst;
    ver_cfg     = VersionRst;
    max_pay_cfg = MaxPayloadRst;
    clear_frame_state();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (frame_rows[i]) begin
      build_frame(frame_rows[i].sb, frame_rows[i].ver, frame_rows[i].flags,
                  frame_rows[i].cmd, frame_rows[i].seq, frame_rows[i].len,
                  frame_rows[i].n_bytes, frame_rows[i].crc_flip, 1'b1, fb);
      send_frame(fb, 1'b1, frame_rows[i].want);
    end

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_START_BYTE, 16'h00AA);
          write_reg(CFG_VERSION_BYTE, 16'h0001);
          write_reg(CFG_MAX_PAYLOAD, 16'd256);
        end
        1: begin
          write_reg(CFG_START_BYTE, 16'h0000);
          write_reg(CFG_VERSION_BYTE, 16'h0000);
          write_reg(CFG_MAX_PAYLOAD, 16'h0000);
        end
        2: begin
          write_reg(CFG_START_BYTE, 16'hFFFF);
          write_reg(CFG_VERSION_BYTE, 16'h00FF);
          write_reg(CFG_MAX_PAYLOAD, 16'hFFFF);
        end
        3: begin
          write_reg(CFG_START_BYTE, 16'($urandom));
          write_reg(CFG_VERSION_BYTE, 16'($urandom));
          write_reg(CFG_MAX_PAYLOAD, 16'd4);
        end
        default: begin
          write_reg(CFG_START_BYTE, 16'($urandom));
          write_reg(CFG_VERSION_BYTE, 16'($urandom));
          write_reg(CFG_MAX_PAYLOAD, 16'($urandom));
        end
      endcase
      sent = 0;
      while (sent < ItemsPerPhase) begin
        random_frame(fb);
        send_frame(fb, 1'b0, ST_OK);
        sent += fb.size();
      end
    end

    settle();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Receiver: segments of differing readiness, and one long hold-off once
  // traffic is flowing so that the checker backs up into its input.
  initial begin : receiver
    int mode;
    int seg;
    int k;
    bit held;
    held = 1'b0;
    k    = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 200);
      repeat (seg) begin
        @(negedge clk);
        if (!held && results_seen >= 60) begin
          held       = 1'b1;
          out_tready = 1'b0;
          repeat (HoldCycles) @(negedge clk);
        end
        k++;
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = $urandom_range(0, 1);
          2: out_tready = ($urandom_range(0, 3) == 0);
          default: out_tready = (k % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: result with nothing expected: expected none, got kind %b data %h",
                     $time, out_tuser, out_tdata);
        end else begin
          want = expected_q.pop_front();
          check_field("result_kind", 16'(want.kind), 16'(out_tuser));
          check_field("payload_byte", 16'(want.pay), 16'(out_tdata[7:0]));
          check_field("status", 16'(want.status), 16'(out_tdata[10:8]));
          check_field("frame_flags", 16'(want.flags), 16'(out_tdata[18:11]));
          check_field("command", 16'(want.cmd), 16'(out_tdata[26:19]));
          check_field("sequence_res", want.seq, out_tdata[42:27]);
          check_field("payload_length", want.len, out_tdata[58:43]);
          check_field("pad bits", 16'h0000, 16'(out_tdata[63:59]));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

endmodule
